/* design/assert_macros.svh */
// Assertion macros for the design files; the top level includes them.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define IPYI_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// expression must never be true at a clock edge out of reset
`define IPYI_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

/* design/ipyi_pkg.sv */
// Package for the planar yaw integrator: state, command and status types,
// register indexes and fixed constants. No dependencies.
package ipyi_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MAX,
		ST_MAY,
		ST_MAZ,
		ST_MLO,
		ST_MHI,
		ST_MSS,
		ST_MRATE,
		ST_RATE,
		ST_MN,
		ST_DIV1,
		ST_WAIT1,
		ST_SUM,
		ST_CHECK,
		ST_WAIT2,
		ST_FIN,
		ST_OUT
	} ipyi_state_t;

	typedef enum logic [2:0] {
		MUL_AX,
		MUL_AY,
		MUL_AZ,
		MUL_LO,
		MUL_HI,
		MUL_SS,
		MUL_RATE,
		MUL_N
	} ipyi_mul_sel_t;

	typedef struct packed {
		logic          load;
		ipyi_mul_sel_t mul_sel;
		logic          ss_init;
		logic          ss_add;
		logic          lo_cap;
		logic          hi_cap;
		logic          ss_cap;
		logic          rate_cap;
		logic          div_inc;
		logic          sum;
		logic          check;
		logic          wrap_fin;
		logic          out_load;
	} ipyi_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic in_range;
		logic out_free;
	} ipyi_sts_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LSB   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_NEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL     = 3'd7;

	localparam logic [15:0] RST_ACCEL_LSB  = 16'd16384;
	localparam logic [14:0] RST_GYRO_LIMIT = 15'd9;
	localparam logic [15:0] RST_RATE_SCALE = 16'd3996;
	localparam logic [15:0] RST_STILL_NEED = 16'd100;
	localparam logic [15:0] RST_DEADBAND   = 16'd3277;
	localparam logic [7:0]  RST_MIN_GAP    = 8'd5;
	localparam logic [7:0]  RST_MAX_GAP    = 8'd30;
	localparam logic [7:0]  RST_NOMINAL    = 8'd10;

	// stillness band: (47 L)^2 <= 2500 * |a|^2 <= (53 L)^2
	localparam logic [21:0] STILL_LO_K    = 22'd47;
	localparam logic [21:0] STILL_HI_K    = 22'd53;
	localparam logic [12:0] STILL_NUM     = 13'd2500;
	localparam logic [15:0] STILL_CNT_MAX = 16'hFFFF;

	function automatic logic [16:0] abs16(input logic signed [15:0] v);
		logic signed [16:0] e;
		e = {v[15], v};
		return e[16] ? 17'(-e) : 17'(e);
	endfunction

endpackage

/* design/ipyi_divider.sv */
// Restoring divider, two quotient bits per cycle, shared by the increment
// scaling and the heading wrap. Depends on nothing.
module ipyi_divider #(
	parameter int DVW = 44,
	parameter int DSW = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVW-1:0] dividend,
	input  logic [DSW-1:0] divisor,
	output logic           busy,
	output logic [DVW-1:0] quot,
	output logic [DSW-1:0] rem
);

	localparam int ITER = (DVW + 1) / 2;
	localparam int PW   = 2 * ITER;
	localparam int CW   = $clog2(ITER + 1);

	logic [PW-1:0]  dq_q;
	logic [DSW-1:0] rem_q;
	logic [DSW-1:0] dvs_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;

	logic [DSW:0]   r1a, r1b;
	logic           ge_a, ge_b;
	logic [DSW-1:0] rem_a, rem_b;

	always_comb begin
		r1a   = {rem_q, dq_q[PW-1]};
		ge_a  = r1a >= {1'b0, dvs_q};
		rem_a = ge_a ? DSW'(r1a - {1'b0, dvs_q}) : r1a[DSW-1:0];
		r1b   = {rem_a, dq_q[PW-2]};
		ge_b  = r1b >= {1'b0, dvs_q};
		rem_b = ge_b ? DSW'(r1b - {1'b0, dvs_q}) : r1b[DSW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ITER);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= PW'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[PW-3:0], ge_a, ge_b};
			rem_q <= rem_b;
		end
	end

	assign busy = busy_q;
	assign quot = dq_q[DVW-1:0];
	assign rem  = rem_q;

endmodule

/* design/ipyi_datapath.sv */
// Datapath: configuration registers, heading state, shared multiplier,
// stillness test and divider. Depends on ipyi_pkg and ipyi_divider.
module ipyi_datapath #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ipyi_pkg::ipyi_cmd_t                   cmd,
	output ipyi_pkg::ipyi_sts_t                   sts,
	input  logic                                  cfg_we,
	input  logic [ipyi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ipyi_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [15:0]                    gyro_x,
	input  logic signed [15:0]                    gyro_y,
	input  logic signed [15:0]                    gyro_z,
	input  logic signed [15:0]                    accel_x,
	input  logic signed [15:0]                    accel_y,
	input  logic signed [15:0]                    accel_z,
	input  logic signed [15:0]                    raw_accel_z,
	input  logic [31:0]                           tick_ms,
	input  logic                                  cal_done_event,
	input  logic                                  bias_stable,
	input  logic                                  cal_active,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic signed [24:0]                    heading_q16,
	output logic signed [31:0]                    rate_q16,
	output logic                                  is_still,
	output logic                                  adapt_request,
	output logic                                  timing_ok,
	output logic [31:0]                           sequence_res
);

	localparam int F     = FRACTION_BITS;
	localparam int HW    = F + 9;
	localparam int SH_UP = (F > 16) ? F - 16 : 0;
	localparam int SH_DN = (F < 16) ? 16 - F : 0;
	localparam int MAGW  = 42 + SH_UP;
	localparam int SW    = 44 + SH_UP;
	localparam int DSW   = (F + 9 > 11 + SH_DN) ? F + 9 : 11 + SH_DN;
	localparam int MW    = 34;
	localparam int PW    = 46;

	localparam logic [HW-1:0]   H_POS    = HW'(64'd180 << F);
	localparam logic [DSW-1:0]  P_DIV    = DSW'(64'd360 << F);
	localparam logic [DSW-1:0]  DEN_DIV  = DSW'(64'd2000 << SH_DN);
	localparam logic [MAGW-1:0] DEN_HALF = MAGW'(64'd1000 << SH_DN);

	// configuration
	logic [15:0] lsb_q, scale_q, need_q, db_q;
	logic [14:0] lim_q;
	logic [7:0]  min_q, max_q, nom_q;

	// heading state
	logic [HW-1:0]    heading_q;
	logic signed [31:0] prev_rate_q;
	logic [15:0]      still_cnt_q;
	logic             sign_neg_q;
	logic [31:0]      sample_cnt_q;
	logic [31:0]      last_tick_q;
	logic             last_tick_vld_q;

	// per-item work registers
	logic signed [15:0] gx_q, gy_q, gz_q, ax_q, ay_q, az_q;
	logic               bias_q, calact_q, contig_q;
	logic [7:0]         gap_q;
	logic [PW-1:0]      prod_q;
	logic [31:0]        sumsq_q;
	logic [PW-1:0]      lo_q, hi_q, ss_q;
	logic signed [31:0] rate_q;
	logic               still_q, adapt_q, nneg_q, wneg_q;
	logic [SW-1:0]      v_q;

	// output register
	logic               out_valid_q;
	logic [24:0]        heading_o_q;
	logic [31:0]        rate_o_q;
	logic               still_o_q, adapt_o_q, timing_o_q;
	logic [31:0]        seq_o_q;

	// load-time logic
	logic [31:0]        gap32;
	logic               contig_c;
	logic signed [16:0] raz17, half17;
	logic               mount_c;

	always_comb begin
		gap32    = last_tick_vld_q ? tick_ms - last_tick_q : {24'd0, nom_q};
		contig_c = (gap32 >= {24'd0, min_q}) && (gap32 <= {24'd0, max_q});
		raz17    = {raw_accel_z[15], raw_accel_z};
		half17   = $signed({2'b00, lsb_q[15:1]});
		mount_c  = (raz17 >= half17) || (raz17 <= -half17);
	end

	// shared multiplier
	logic [21:0]           l47, l53;
	logic signed [32:0]    sum33;
	logic signed [MW-1:0]  mul_a, mul_b;
	logic signed [2*MW-1:0] prod_full;

	always_comb begin
		l47   = {6'd0, lsb_q} * ipyi_pkg::STILL_LO_K;
		l53   = {6'd0, lsb_q} * ipyi_pkg::STILL_HI_K;
		sum33 = {prev_rate_q[31], prev_rate_q} + {rate_q[31], rate_q};
		unique case (cmd.mul_sel)
			ipyi_pkg::MUL_AX: begin
				mul_a = {{18{ax_q[15]}}, ax_q};
				mul_b = {{18{ax_q[15]}}, ax_q};
			end
			ipyi_pkg::MUL_AY: begin
				mul_a = {{18{ay_q[15]}}, ay_q};
				mul_b = {{18{ay_q[15]}}, ay_q};
			end
			ipyi_pkg::MUL_AZ: begin
				mul_a = {{18{az_q[15]}}, az_q};
				mul_b = {{18{az_q[15]}}, az_q};
			end
			ipyi_pkg::MUL_LO: begin
				mul_a = {12'd0, l47};
				mul_b = {12'd0, l47};
			end
			ipyi_pkg::MUL_HI: begin
				mul_a = {12'd0, l53};
				mul_b = {12'd0, l53};
			end
			ipyi_pkg::MUL_SS: begin
				mul_a = {2'b00, sumsq_q};
				mul_b = {21'd0, ipyi_pkg::STILL_NUM};
			end
			ipyi_pkg::MUL_RATE: begin
				mul_a = {{18{gz_q[15]}}, gz_q};
				mul_b = {18'd0, scale_q};
			end
			ipyi_pkg::MUL_N: begin
				mul_a = contig_q ? {sum33[32], sum33} : {{2{rate_q[31]}}, rate_q};
				mul_b = contig_q ? {26'd0, gap_q} : {25'd0, nom_q, 1'b0};
			end
		endcase
		prod_full = mul_a * mul_b;
	end

	// rate and stillness
	logic signed [31:0] rate_raw, rate_sg;
	logic [31:0]        rate_abs;
	logic               still_c;
	logic [15:0]        cnt_inc;
	logic [16:0]        lim17;

	always_comb begin
		rate_raw = $signed(prod_q[31:0]);
		rate_sg  = sign_neg_q ? -rate_raw : rate_raw;
		rate_abs = rate_sg[31] ? 32'(-rate_sg) : 32'(rate_sg);
		lim17    = {2'b00, lim_q};
		still_c  = (ss_q >= lo_q) && (ss_q <= hi_q) &&
			(ipyi_pkg::abs16(gx_q) <= lim17) &&
			(ipyi_pkg::abs16(gy_q) <= lim17) &&
			(ipyi_pkg::abs16(gz_q) <= lim17);
		cnt_inc  = (still_cnt_q != ipyi_pkg::STILL_CNT_MAX) ? still_cnt_q + 16'd1 : still_cnt_q;
	end

	// increment scaling and wrap
	logic [PW-1:0]   n_mag;
	logic [MAGW-1:0] div_inc_a;
	logic [SW-1:0]   inc_mag, inc, hp, v_c, t_c;
	logic            v_hi, v_lo;
	logic            div_start, div_busy;
	logic [SW-1:0]   div_dvd, div_quot;
	logic [DSW-1:0]  div_dvs, div_rem;
	logic [HW-1:0]   remh;

	always_comb begin
		n_mag     = prod_q[PW-1] ? PW'(-prod_q) : prod_q;
		div_inc_a = (MAGW'(n_mag[40:0]) << SH_UP) + DEN_HALF;
		inc_mag   = SW'(div_quot[MAGW-1:0]);
		inc       = nneg_q ? SW'(0) - inc_mag : inc_mag;
		v_c       = {{(SW-HW){heading_q[HW-1]}}, heading_q} + inc;
		hp        = SW'(H_POS);
		v_hi      = $signed(v_q) > $signed(hp);
		v_lo      = $signed(v_q) < -$signed(hp);
		t_c       = v_hi ? v_q - hp - SW'(1) : SW'(0) - hp - v_q - SW'(1);
		div_start = cmd.div_inc || (cmd.check && (v_hi || v_lo));
		div_dvd   = cmd.div_inc ? SW'(div_inc_a) : t_c;
		div_dvs   = cmd.div_inc ? DEN_DIV : P_DIV;
		remh      = div_rem[HW-1:0];
	end

	ipyi_divider #(
		.DVW (SW),
		.DSW (DSW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsb_q           <= ipyi_pkg::RST_ACCEL_LSB;
			lim_q           <= ipyi_pkg::RST_GYRO_LIMIT;
			scale_q         <= ipyi_pkg::RST_RATE_SCALE;
			need_q          <= ipyi_pkg::RST_STILL_NEED;
			db_q            <= ipyi_pkg::RST_DEADBAND;
			min_q           <= ipyi_pkg::RST_MIN_GAP;
			max_q           <= ipyi_pkg::RST_MAX_GAP;
			nom_q           <= ipyi_pkg::RST_NOMINAL;
			heading_q       <= '0;
			prev_rate_q     <= '0;
			still_cnt_q     <= '0;
			sign_neg_q      <= 1'b1;
			sample_cnt_q    <= '0;
			last_tick_q     <= '0;
			last_tick_vld_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ipyi_pkg::REG_ACCEL_LSB:  lsb_q   <= cfg_data;
					ipyi_pkg::REG_GYRO_LIMIT: lim_q   <= cfg_data[14:0];
					ipyi_pkg::REG_RATE_SCALE: scale_q <= cfg_data;
					ipyi_pkg::REG_STILL_NEED: need_q  <= cfg_data;
					ipyi_pkg::REG_DEADBAND:   db_q    <= cfg_data;
					ipyi_pkg::REG_MIN_GAP:    min_q   <= cfg_data[7:0];
					ipyi_pkg::REG_MAX_GAP:    max_q   <= cfg_data[7:0];
					ipyi_pkg::REG_NOMINAL:    nom_q   <= cfg_data[7:0];
				endcase
			end
			if (cmd.load) begin
				if (cal_done_event) begin
					heading_q   <= '0;
					prev_rate_q <= '0;
					still_cnt_q <= '0;
				end
				// mount direction is taken from the first item after reset, if its raw z reaches half the LSB
				if (sample_cnt_q == 32'd0 && mount_c) begin
					sign_neg_q <= !raw_accel_z[15];
				end
				sample_cnt_q    <= sample_cnt_q + 32'd1;
				last_tick_q     <= tick_ms;
				last_tick_vld_q <= 1'b1;
			end
			if (cmd.rate_cap) begin
				still_cnt_q <= still_c ? cnt_inc : 16'd0;
			end
			if (cmd.div_inc) begin
				prev_rate_q <= rate_q;
			end
			if (cmd.check && !(v_hi || v_lo)) begin
				heading_q <= v_q[HW-1:0];
			end
			if (cmd.wrap_fin) begin
				heading_q <= wneg_q ? H_POS - HW'(1) - remh : remh + HW'(1) - H_POS;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic [63:0] heading_ext;
	assign heading_ext = {{(64-HW){heading_q[HW-1]}}, heading_q};

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gx_q     <= gyro_x;
			gy_q     <= gyro_y;
			gz_q     <= gyro_z;
			ax_q     <= accel_x;
			ay_q     <= accel_y;
			az_q     <= accel_z;
			bias_q   <= bias_stable;
			calact_q <= cal_active;
			contig_q <= contig_c;
			gap_q    <= gap32[7:0];
		end
		prod_q <= prod_full[PW-1:0];
		if (cmd.ss_init) begin
			sumsq_q <= prod_q[31:0];
		end else if (cmd.ss_add) begin
			sumsq_q <= sumsq_q + prod_q[31:0];
		end
		if (cmd.lo_cap) begin
			lo_q <= prod_q;
		end
		if (cmd.hi_cap) begin
			hi_q <= prod_q;
		end
		if (cmd.ss_cap) begin
			ss_q <= prod_q;
		end
		if (cmd.rate_cap) begin
			rate_q  <= (rate_abs < {16'd0, db_q}) ? 32'sd0 : rate_sg;
			still_q <= still_c;
			adapt_q <= still_c && (cnt_inc >= need_q) && !bias_q && !calact_q;
		end
		if (cmd.div_inc) begin
			nneg_q <= prod_q[PW-1];
		end
		if (cmd.sum) begin
			v_q <= v_c;
		end
		if (cmd.check) begin
			wneg_q <= v_lo;
		end
		if (cmd.out_load) begin
			heading_o_q <= heading_ext[24:0];
			rate_o_q    <= rate_q;
			still_o_q   <= still_q;
			adapt_o_q   <= adapt_q;
			timing_o_q  <= contig_q;
			seq_o_q     <= sample_cnt_q;
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.in_range = !(v_hi || v_lo);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign heading_q16   = $signed(heading_o_q);
	assign rate_q16      = $signed(rate_o_q);
	assign is_still      = still_o_q;
	assign adapt_request = adapt_o_q;
	assign timing_ok     = timing_o_q;
	assign sequence_res  = seq_o_q;

endmodule

/* design/ipyi_ctrl.sv */
// Controller: sequences the multiplier, divider and output register for
// one item at a time. Depends on ipyi_pkg.
module ipyi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ipyi_pkg::ipyi_sts_t sts,
	output ipyi_pkg::ipyi_cmd_t cmd
);

	ipyi_pkg::ipyi_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipyi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ipyi_pkg::ST_IDLE:  if (in_valid) state_d = ipyi_pkg::ST_MAX;
			ipyi_pkg::ST_MAX:   state_d = ipyi_pkg::ST_MAY;
			ipyi_pkg::ST_MAY:   state_d = ipyi_pkg::ST_MAZ;
			ipyi_pkg::ST_MAZ:   state_d = ipyi_pkg::ST_MLO;
			ipyi_pkg::ST_MLO:   state_d = ipyi_pkg::ST_MHI;
			ipyi_pkg::ST_MHI:   state_d = ipyi_pkg::ST_MSS;
			ipyi_pkg::ST_MSS:   state_d = ipyi_pkg::ST_MRATE;
			ipyi_pkg::ST_MRATE: state_d = ipyi_pkg::ST_RATE;
			ipyi_pkg::ST_RATE:  state_d = ipyi_pkg::ST_MN;
			ipyi_pkg::ST_MN:    state_d = ipyi_pkg::ST_DIV1;
			ipyi_pkg::ST_DIV1:  state_d = ipyi_pkg::ST_WAIT1;
			ipyi_pkg::ST_WAIT1: if (!sts.div_busy) state_d = ipyi_pkg::ST_SUM;
			ipyi_pkg::ST_SUM:   state_d = ipyi_pkg::ST_CHECK;
			ipyi_pkg::ST_CHECK: begin
				state_d = sts.in_range ? ipyi_pkg::ST_OUT : ipyi_pkg::ST_WAIT2;
			end
			ipyi_pkg::ST_WAIT2: if (!sts.div_busy) state_d = ipyi_pkg::ST_FIN;
			ipyi_pkg::ST_FIN:   state_d = ipyi_pkg::ST_OUT;
			ipyi_pkg::ST_OUT:   if (sts.out_free) state_d = ipyi_pkg::ST_IDLE;
			default:            state_d = ipyi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = ipyi_pkg::MUL_AX;
		in_ready    = 1'b0;
		unique case (state_q)
			ipyi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ipyi_pkg::ST_MAX: cmd.mul_sel = ipyi_pkg::MUL_AX;
			ipyi_pkg::ST_MAY: begin
				cmd.mul_sel = ipyi_pkg::MUL_AY;
				cmd.ss_init = 1'b1;
			end
			ipyi_pkg::ST_MAZ: begin
				cmd.mul_sel = ipyi_pkg::MUL_AZ;
				cmd.ss_add  = 1'b1;
			end
			ipyi_pkg::ST_MLO: begin
				cmd.mul_sel = ipyi_pkg::MUL_LO;
				cmd.ss_add  = 1'b1;
			end
			ipyi_pkg::ST_MHI: begin
				cmd.mul_sel = ipyi_pkg::MUL_HI;
				cmd.lo_cap  = 1'b1;
			end
			ipyi_pkg::ST_MSS: begin
				cmd.mul_sel = ipyi_pkg::MUL_SS;
				cmd.hi_cap  = 1'b1;
			end
			ipyi_pkg::ST_MRATE: begin
				cmd.mul_sel = ipyi_pkg::MUL_RATE;
				cmd.ss_cap  = 1'b1;
			end
			ipyi_pkg::ST_RATE:  cmd.rate_cap = 1'b1;
			ipyi_pkg::ST_MN:    cmd.mul_sel = ipyi_pkg::MUL_N;
			ipyi_pkg::ST_DIV1:  cmd.div_inc = 1'b1;
			ipyi_pkg::ST_WAIT1: cmd.sum = 1'b0;
			ipyi_pkg::ST_SUM:   cmd.sum = 1'b1;
			ipyi_pkg::ST_CHECK: cmd.check = 1'b1;
			ipyi_pkg::ST_WAIT2: cmd.wrap_fin = 1'b0;
			ipyi_pkg::ST_FIN:   cmd.wrap_fin = 1'b1;
			ipyi_pkg::ST_OUT:   cmd.out_load = sts.out_free;
			default:            cmd.load = 1'b0;
		endcase
	end

endmodule

/* design/imu_planar_yaw_integrator.sv */
// Planar yaw integrator top level: controller, datapath and checks.
// One item at a time; each item uses the divider once for the increment scaling
// and once more when the heading wraps, two quotient bits a cycle.
// Next item is taken once the result is in the output register.
// Asynchronous active-low reset restores register defaults and zero heading.
`include "assert_macros.svh"

module imu_planar_yaw_integrator #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [15:0]              gyro_x,
	input  logic signed [15:0]              gyro_y,
	input  logic signed [15:0]              gyro_z,
	input  logic signed [15:0]              accel_x,
	input  logic signed [15:0]              accel_y,
	input  logic signed [15:0]              accel_z,
	input  logic signed [15:0]              raw_accel_z,
	input  logic [31:0]                     tick_ms,
	input  logic                            cal_done_event,
	input  logic                            bias_stable,
	input  logic                            cal_active,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [24:0]              heading_q16,
	output logic signed [31:0]              rate_q16,
	output logic                            is_still,
	output logic                            adapt_request,
	output logic                            timing_ok,
	output logic [31:0]                     sequence_res,
	input  logic                            cfg_we,
	input  logic [ipyi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipyi_pkg::CFG_DATA_W-1:0] cfg_data
);

	ipyi_pkg::ipyi_cmd_t cmd;
	ipyi_pkg::ipyi_sts_t sts;

	ipyi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ipyi_datapath #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.gyro_x         (gyro_x),
		.gyro_y         (gyro_y),
		.gyro_z         (gyro_z),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.raw_accel_z    (raw_accel_z),
		.tick_ms        (tick_ms),
		.cal_done_event (cal_done_event),
		.bias_stable    (bias_stable),
		.cal_active     (cal_active),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.heading_q16    (heading_q16),
		.rate_q16       (rate_q16),
		.is_still       (is_still),
		.adapt_request  (adapt_request),
		.timing_ok      (timing_ok),
		.sequence_res   (sequence_res)
	);

	`IPYI_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
	`IPYI_ASSERT(a_out_load_free, cmd.out_load |-> sts.out_free)
	`IPYI_ASSERT(a_wrap_starts_div, (cmd.check && !sts.in_range) |=> sts.div_busy)
	`IPYI_ASSERT_NEVER(a_load_while_div, cmd.load && sts.div_busy)

endmodule
